[design/doubly_linked_list_engine_assert.svh]
// Assertion macros used by the checker file of the doubly linked list engine
`ifndef DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH
`define DOUBLY_LINKED_LIST_ENGINE_ASSERT_SVH

// Check a condition in the cycle after the trigger
`define DLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Check a condition in the same cycle as the trigger
`define DLL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[design/dll_pkg.sv]
// Shared constants, types and request/status codes of the doubly linked list engine
package dll_pkg;

  localparam int DEPTH       = 64;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int VALUE_WIDTH = 32;

  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [2:0]                    req_t;
  typedef logic [1:0]                    stat_t;

  // Request codes
  localparam req_t REQ_HEAD   = 3'd0;
  localparam req_t REQ_TAIL   = 3'd1;
  localparam req_t REQ_AFTER  = 3'd2;
  localparam req_t REQ_SEARCH = 3'd3;
  localparam req_t REQ_DELETE = 3'd4;

  // Status codes
  localparam stat_t ST_DONE = 2'd0;
  localparam stat_t ST_NOTF = 2'd1;
  localparam stat_t ST_FULL = 2'd2;

  // Write port of a link or free-stack memory
  typedef struct packed {
    logic we;
    idx_t addr;
    idx_t data;
  } lnk_wr_t;

  // Write port of the value memory
  typedef struct packed {
    logic we;
    idx_t addr;
    val_t data;
  } val_wr_t;

endpackage

[design/dll_if.sv]
// Request and response channel interfaces of the doubly linked list engine
interface dll_req_if;
  logic          valid;
  logic          ready;
  dll_pkg::req_t req_type;
  dll_pkg::val_t value;
  dll_pkg::val_t key;

  modport source (output valid, output req_type, output value, output key, input ready);
  modport sink   (input valid, input req_type, input value, input key, output ready);
  modport mon    (input valid, input req_type, input value, input key, input ready);
endinterface

interface dll_rsp_if;
  logic           valid;
  logic           ready;
  logic           found;
  dll_pkg::stat_t status;
  dll_pkg::cnt_t  count;

  modport source (output valid, output found, output status, output count, input ready);
  modport sink   (input valid, input found, input status, input count, output ready);
  modport mon    (input valid, input found, input status, input count, input ready);
endinterface

[design/dll_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/dll_ctrl.sv]
// Sequencer: list walk, node allocation, link update and response register
module dll_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  dll_req_if.sink          in_req,
  dll_rsp_if.source        out_rsp,
  output dll_pkg::idx_t    node_raddr,
  output dll_pkg::idx_t    fs_raddr,
  output dll_pkg::val_wr_t val_wr,
  output dll_pkg::lnk_wr_t nxt_wr,
  output dll_pkg::lnk_wr_t prv_wr,
  output dll_pkg::lnk_wr_t fs_wr,
  input  dll_pkg::val_t    val_rd,
  input  dll_pkg::idx_t    nxt_rd,
  input  dll_pkg::idx_t    prv_rd,
  input  dll_pkg::idx_t    fs_rd
);

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_INS1, S_INS2, S_DEL, S_RESP
  } state_t;

  localparam dll_pkg::cnt_t CNT_ONE  = dll_pkg::cnt_t'(1);
  localparam dll_pkg::cnt_t CNT_FULL = dll_pkg::cnt_t'(dll_pkg::DEPTH);

  state_t         state_r,  state_nxt;
  dll_pkg::idx_t  head_r,   head_nxt;
  dll_pkg::idx_t  tail_r,   tail_nxt;
  dll_pkg::cnt_t  cnt_r,    cnt_nxt;
  dll_pkg::cnt_t  fresh_r,  fresh_nxt;   // nodes ever handed out from the fresh pool
  dll_pkg::cnt_t  fsp_r,    fsp_nxt;     // depth of the freed-node stack
  dll_pkg::cnt_t  left_r,   left_nxt;    // nodes still to visit in a walk
  dll_pkg::req_t  req_r,    req_nxt;
  dll_pkg::val_t  val_r,    val_nxt;
  dll_pkg::val_t  tgt_r,    tgt_nxt;
  dll_pkg::idx_t  cur_r,    cur_nxt;
  dll_pkg::idx_t  t_r,      t_nxt;
  dll_pkg::idx_t  nt_r,     nt_nxt;
  dll_pkg::idx_t  pt_r,     pt_nxt;
  dll_pkg::idx_t  n_r,      n_nxt;
  logic           tl_r,     tl_nxt;
  logic           found_r,  found_nxt;
  dll_pkg::stat_t status_r, status_nxt;

  dll_pkg::cnt_t  fs_top;
  dll_pkg::idx_t  new_node;
  logic           hit;

  // Top of the freed stack is always being read; reuse freed nodes first
  assign fs_top   = fsp_r - CNT_ONE;
  assign fs_raddr = fs_top[dll_pkg::IDX_W-1:0];
  assign new_node = (fsp_r != '0) ? fs_rd : fresh_r[dll_pkg::IDX_W-1:0];

  // Follow the forward link while walking, else point at the head
  assign node_raddr = (state_r == S_WALK) ? nxt_rd : head_r;

  // Shared compare unit
  assign hit = (val_rd == tgt_r);

  assign in_req.ready   = (state_r == S_IDLE);
  assign out_rsp.valid  = (state_r == S_RESP);
  assign out_rsp.found  = found_r;
  assign out_rsp.status = status_r;
  assign out_rsp.count  = cnt_r;

  // Sequence one request
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    fresh_nxt  = fresh_r;
    fsp_nxt    = fsp_r;
    left_nxt   = left_r;
    req_nxt    = req_r;
    val_nxt    = val_r;
    tgt_nxt    = tgt_r;
    cur_nxt    = cur_r;
    t_nxt      = t_r;
    nt_nxt     = nt_r;
    pt_nxt     = pt_r;
    n_nxt      = n_r;
    tl_nxt     = tl_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    val_wr     = '0;
    nxt_wr     = '0;
    prv_wr     = '0;
    fs_wr      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          req_nxt    = in_req.req_type;
          val_nxt    = in_req.value;
          tgt_nxt    = (in_req.req_type == dll_pkg::REQ_AFTER) ? in_req.key : in_req.value;
          t_nxt      = (in_req.req_type == dll_pkg::REQ_HEAD) ? head_r : tail_r;
          cur_nxt    = head_r;
          left_nxt   = cnt_r;
          found_nxt  = 1'b0;
          status_nxt = dll_pkg::ST_DONE;
          case (in_req.req_type)
            dll_pkg::REQ_HEAD, dll_pkg::REQ_TAIL: begin
              if (cnt_r == CNT_FULL) begin
                status_nxt = dll_pkg::ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_INS1;
              end
            end
            dll_pkg::REQ_AFTER, dll_pkg::REQ_SEARCH, dll_pkg::REQ_DELETE: begin
              if (cnt_r == '0) begin
                status_nxt = dll_pkg::ST_NOTF;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      S_WALK: begin
        if (hit) begin
          found_nxt = 1'b1;
          t_nxt     = cur_r;
          nt_nxt    = nxt_rd;
          pt_nxt    = prv_rd;
          case (req_r)
            dll_pkg::REQ_SEARCH: state_nxt = S_RESP;
            dll_pkg::REQ_DELETE: state_nxt = S_DEL;
            default: begin
              if (cnt_r == CNT_FULL) begin
                status_nxt = dll_pkg::ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_INS1;
              end
            end
          endcase
        end else if (left_r == CNT_ONE) begin
          status_nxt = dll_pkg::ST_NOTF;
          state_nxt  = S_RESP;
        end else begin
          cur_nxt  = nxt_rd;
          left_nxt = left_r - CNT_ONE;
        end
      end

      S_INS1: begin
        // Fill the new node and move head or tail onto it where it takes that place
        val_wr = '{we: 1'b1, addr: new_node, data: val_r};
        nxt_wr = '{we: 1'b1, addr: new_node,
                   data: (req_r == dll_pkg::REQ_HEAD) ? t_r : nt_r};
        prv_wr = '{we: 1'b1, addr: new_node, data: t_r};
        n_nxt  = new_node;
        tl_nxt = (t_r == tail_r);
        if (fsp_r != '0) begin
          fsp_nxt = fs_top;
        end else begin
          fresh_nxt = fresh_r + CNT_ONE;
        end
        case (req_r)
          dll_pkg::REQ_HEAD: begin
            head_nxt = new_node;
            if (cnt_r == '0) begin
              tail_nxt = new_node;
            end
          end
          dll_pkg::REQ_TAIL: begin
            tail_nxt = new_node;
            if (cnt_r == '0) begin
              head_nxt = new_node;
            end
          end
          default: begin
            if (t_r == tail_r) begin
              tail_nxt = new_node;
            end
          end
        endcase
        state_nxt = S_INS2;
      end

      S_INS2: begin
        // Link the neighbors to the new node
        nxt_wr.we   = ((req_r == dll_pkg::REQ_TAIL) && (cnt_r != '0)) ||
                      (req_r == dll_pkg::REQ_AFTER);
        nxt_wr.addr = t_r;
        nxt_wr.data = n_r;
        prv_wr.data = n_r;
        if ((req_r == dll_pkg::REQ_HEAD) && (cnt_r != '0)) begin
          prv_wr.we   = 1'b1;
          prv_wr.addr = t_r;
        end else if ((req_r == dll_pkg::REQ_AFTER) && !tl_r) begin
          prv_wr.we   = 1'b1;
          prv_wr.addr = nt_r;
        end
        cnt_nxt   = cnt_r + CNT_ONE;
        state_nxt = S_RESP;
      end

      S_DEL: begin
        // Unlink the node and push it on the freed stack
        if (cnt_r != CNT_ONE) begin
          if (t_r == head_r) begin
            head_nxt = nt_r;
          end else if (t_r == tail_r) begin
            tail_nxt = pt_r;
          end else begin
            nxt_wr = '{we: 1'b1, addr: pt_r, data: nt_r};
            prv_wr = '{we: 1'b1, addr: nt_r, data: pt_r};
          end
        end
        fs_wr     = '{we: 1'b1, addr: fsp_r[dll_pkg::IDX_W-1:0], data: t_r};
        fsp_nxt   = fsp_r + CNT_ONE;
        cnt_nxt   = cnt_r - CNT_ONE;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      fresh_r <= '0;
      fsp_r   <= '0;
      left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      fresh_r <= fresh_nxt;
      fsp_r   <= fsp_nxt;
      left_r  <= left_nxt;
    end
    req_r    <= req_nxt;
    val_r    <= val_nxt;
    tgt_r    <= tgt_nxt;
    cur_r    <= cur_nxt;
    t_r      <= t_nxt;
    nt_r     <= nt_nxt;
    pt_r     <= pt_nxt;
    n_r      <= n_nxt;
    tl_r     <= tl_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

endmodule

[design/doubly_linked_list_engine.sv]
// Insert head/tail: accept, fill the new node, link its neighbors, then present the response;
// a full store goes straight to the response. Search, delete and insert-after first walk up to DEPTH nodes.
// Throughput: one request at a time; the next beat is taken after the response beat,
// bounded by the one-node-per-cycle walk through the value and link memories.
// Reset: synchronous, active low; the list is empty and ready once reset is released,
// with no memory clearing pass.
module doubly_linked_list_engine (
  input logic       clk,
  input logic       rst_n,
  dll_req_if.sink   in_req,
  dll_rsp_if.source out_rsp
);

  dll_pkg::idx_t    node_raddr;
  dll_pkg::idx_t    fs_raddr;
  dll_pkg::val_wr_t val_wr;
  dll_pkg::lnk_wr_t nxt_wr;
  dll_pkg::lnk_wr_t prv_wr;
  dll_pkg::lnk_wr_t fs_wr;
  dll_pkg::val_t    val_rd;
  dll_pkg::idx_t    nxt_rd;
  dll_pkg::idx_t    prv_rd;
  dll_pkg::idx_t    fs_rd;

  // Sequencer
  dll_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .out_rsp    (out_rsp),
    .node_raddr (node_raddr),
    .fs_raddr   (fs_raddr),
    .val_wr     (val_wr),
    .nxt_wr     (nxt_wr),
    .prv_wr     (prv_wr),
    .fs_wr      (fs_wr),
    .val_rd     (val_rd),
    .nxt_rd     (nxt_rd),
    .prv_rd     (prv_rd),
    .fs_rd      (fs_rd)
  );

  // Node values
  dll_ram #(.WIDTH(dll_pkg::VALUE_WIDTH), .DEPTH(dll_pkg::DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_wr.we),
    .waddr (val_wr.addr),
    .wdata (val_wr.data),
    .raddr (node_raddr),
    .rdata (val_rd)
  );

  // Forward links
  dll_ram #(.WIDTH(dll_pkg::IDX_W), .DEPTH(dll_pkg::DEPTH)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_wr.we),
    .waddr (nxt_wr.addr),
    .wdata (nxt_wr.data),
    .raddr (node_raddr),
    .rdata (nxt_rd)
  );

  // Backward links
  dll_ram #(.WIDTH(dll_pkg::IDX_W), .DEPTH(dll_pkg::DEPTH)) u_prv_ram (
    .clk   (clk),
    .we    (prv_wr.we),
    .waddr (prv_wr.addr),
    .wdata (prv_wr.data),
    .raddr (node_raddr),
    .rdata (prv_rd)
  );

  // Freed-node stack
  dll_ram #(.WIDTH(dll_pkg::IDX_W), .DEPTH(dll_pkg::DEPTH)) u_fs_ram (
    .clk   (clk),
    .we    (fs_wr.we),
    .waddr (fs_wr.addr),
    .wdata (fs_wr.data),
    .raddr (fs_raddr),
    .rdata (fs_rd)
  );

endmodule

[design/dll_chk.sv]
// Port-level checker of the doubly linked list engine and its bind
`include "doubly_linked_list_engine_assert.svh"

module dll_chk (
  input logic       clk,
  input logic       rst_n,
  dll_req_if.sink   in_req,
  dll_rsp_if.source out_rsp
);

  // Busy after taking a request beat
  `DLL_ASSERT_NEXT(a_busy_after_accept, in_req.valid && in_req.ready, !in_req.ready, "ready after accept")

  // No new request while a response beat is pending
  `DLL_ASSERT_NOW(a_no_overlap, out_rsp.valid, !in_req.ready, "request taken with response pending")

  // A hit never reports a miss
  `DLL_ASSERT_NOW(a_found_status, out_rsp.valid && out_rsp.found, out_rsp.status != dll_pkg::ST_NOTF, "found with not-found status")

  // Full status only with a full list
  `DLL_ASSERT_NOW(a_full_count, out_rsp.valid && (out_rsp.status == dll_pkg::ST_FULL), out_rsp.count == dll_pkg::cnt_t'(dll_pkg::DEPTH), "full status below capacity")

  // Stalled response beat holds
  `DLL_ASSERT_NEXT(a_rsp_hold, out_rsp.valid && !out_rsp.ready, out_rsp.valid && $stable(out_rsp.found) && $stable(out_rsp.status) && $stable(out_rsp.count), "stalled response changed")

endmodule

bind doubly_linked_list_engine dll_chk u_dll_chk (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_req  (in_req),
  .out_rsp (out_rsp)
);
